// ===== hw/rtl/integer_square_root_top_macros.svh =====
// Assertion macros for the checker file of the square root block.
`ifndef INTEGER_SQUARE_ROOT_TOP_MACROS_SVH
`define INTEGER_SQUARE_ROOT_TOP_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ISR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ISR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/isr_pkg.sv =====
`default_nettype none

package isr_pkg;

    // Field widths.
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;

    // Divider step counter: one quotient bit per cycle.
    localparam int CNT_W  = $clog2(RAD_W);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new radicand and prime the first division
        logic div_step;  // one restoring division step
        logic update;    // form the new estimate and restart the divider if it improved
        logic out_load;  // copy the best estimate into the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tiny;      // incoming radicand is zero or one
        logic div_last;  // the current division step is the last one
        logic improved;  // new estimate lies below the best one so far
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/isr_datapath.sv =====
`default_nettype none

module isr_datapath
    import isr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [RAD_W-1:0]  i_radicand,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    output logic [ROOT_W-1:0]      o_root
);

    logic [RAD_W-1:0]  r_val,  n_val;
    logic [RAD_W-1:0]  r_est,  n_est;
    logic [RAD_W-1:0]  r_best, n_best;
    logic [RAD_W-1:0]  r_rem,  n_rem;
    logic [RAD_W-1:0]  r_quo,  n_quo;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [RAD_W:0]    shifted;
    logic [RAD_W+1:0]  diff;
    logic              borrow;
    logic [RAD_W:0]    sum;
    logic [RAD_W-1:0]  avg;
    logic              improved;

    // Restoring division step: shift in the next dividend bit and try to subtract.
    always_comb begin
        shifted = {r_rem, r_quo[RAD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_est};
        borrow  = diff[RAD_W+1];
    end

    // Newton average of the estimate and the finished quotient.
    always_comb begin
        sum      = {1'b0, r_quo} + {1'b0, r_est};
        avg      = sum[RAD_W:1];
        improved = (avg < r_best);
    end

    // Next values of the datapath registers.
    always_comb begin
        n_val  = r_val;
        n_est  = r_est;
        n_best = r_best;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_root = r_root;
        if (i_cmd.load) begin
            n_val  = i_radicand;
            n_best = i_radicand;
            n_est  = i_radicand >> 1;
            n_rem  = '0;
            n_quo  = i_radicand;
            n_cnt  = '0;
        end else if (i_cmd.div_step) begin
            n_rem  = borrow ? shifted[RAD_W-1:0] : diff[RAD_W-1:0];
            n_quo  = {r_quo[RAD_W-2:0], ~borrow};
            n_cnt  = r_cnt + 1'b1;
        end else if (i_cmd.update && improved) begin
            n_est  = avg;
            n_best = avg;
            n_rem  = '0;
            n_quo  = r_val;
            n_cnt  = '0;
        end
        if (i_cmd.out_load) begin
            n_root = r_best[ROOT_W-1:0];
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_est  <= n_est;
        r_best <= n_best;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_root <= n_root;
    end

    // Status back to the controller.
    always_comb begin
        o_sts.tiny     = (i_radicand[RAD_W-1:1] == '0);
        o_sts.div_last = (r_cnt == {CNT_W{1'b1}});
        o_sts.improved = improved;
    end

    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hw/rtl/isr_ctrl.sv =====
`default_nettype none

module isr_ctrl
    import isr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_stall,
    output logic         o_out_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Sequencing of one word: divide, update, repeat until the estimate stops falling.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.tiny ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.improved ? ST_DIV : ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid holds until the result word is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_square_root_top.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+------------------
// input    | i_in_valid   | o_in_stall   | i_radicand [31:0]
// output   | o_out_valid  | i_out_stall  | o_root     [15:0]
//
// Zero or one skips the division; the finish state loads it into the result register.
// Larger radicands run Newton steps until the estimate stops falling, each a shared
// bit-serial division followed by one update.
// One word is in work at a time; the next is taken once the result is loaded.
// Reset is synchronous and active low; it clears the controller and output valid.
// A stalled result holds in its register while the next word is accepted and computed.
`default_nettype none

module integer_square_root_top
    import isr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [RAD_W-1:0]  i_radicand,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ROOT_W-1:0]      o_root
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller state machine.
    isr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Divider, estimate registers and result register.
    isr_datapath u_dp (
        .i_clk      (i_clk),
        .i_radicand (i_radicand),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_root     (o_root)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/isr_chk.sv =====
`default_nettype none

`include "integer_square_root_top_macros.svh"

module isr_chk
    import isr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [ROOT_W-1:0] o_root
);

    logic out_held;
    logic in_take;
    logic idle_out_take;

    // Handshake conditions for the checks below.
    assign out_held      = o_out_valid && i_out_stall;
    assign in_take       = i_in_valid && !o_in_stall;
    assign idle_out_take = o_out_valid && !i_out_stall && !o_in_stall;

    // A stalled result word stays valid and unchanged.
    `ISR_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_root), "stalled result changed")

    // Taking a word puts the block to work, so it stalls its input next cycle.
    `ISR_ASSERT(a_busy, in_take |=> o_in_stall, "input not stalled")

    // No result can complete in the cycle after an idle block hands off its result.
    `ISR_ASSERT(a_no_phantom, idle_out_take |=> !o_out_valid, "result with no work")

    // Reset leaves the block idle with no result pending.
    `ISR_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && !o_in_stall, "busy after reset")

endmodule

bind integer_square_root_top isr_chk u_isr_chk (.*);

`default_nettype wire
